@@ sv/pftex_pkg.sv @@
// shared constants and types for the fire / forcefield texture block
package pftex_pkg;

	localparam int PIX_W       = 8;
	localparam int GRID_W      = 32;
	localparam int COL_W       = $clog2(GRID_W);
	localparam int GRID_CELLS  = GRID_W * GRID_W;
	localparam int IDX_W       = $clog2(GRID_CELLS);
	localparam int EXT_W       = IDX_W + 1;
	localparam int STORE_DEPTH = 2 * GRID_CELLS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int HOT_W       = 5;
	localparam int NUM_HOT     = 9;
	localparam int SPOT_W      = $clog2(NUM_HOT);
	localparam int STEP_W      = 3;
	localparam int CLR_W       = ADDR_W;

	localparam int BOTTOM_ROW  = 992;
	localparam int FIRE_BASE   = 1008;
	localparam int HOT_BIAS    = 15;
	localparam int LAST_IN     = 30;
	localparam logic [PIX_W-1:0] PIX_HOT = 8'hff;

	typedef enum logic {
		KIND_FRAME = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

	typedef enum logic {
		MODE_FIRE  = 1'b0,
		MODE_FORCE = 1'b1
	} mode_t;

	typedef logic [NUM_HOT-1:0][HOT_W-1:0] hot_arr_t;

	typedef struct packed {
		logic             we;
		logic             wfront;
		logic [IDX_W-1:0] widx;
		logic [PIX_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] ridx;
	} mreq_t;

endpackage

@@ sv/pftex_ram.sv @@
// generic single-write, single-read synchronous ram with registered read
module pftex_ram #(
	parameter int W = 8,
	parameter int D = 2048,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/pftex_frame.sv @@
// frame sequencer: fire-mode row clear, hot spot stamps and neighbour-sum sweep
module pftex_frame (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           mode,
	input  pftex_pkg::hot_arr_t            hot,
	input  logic [pftex_pkg::PIX_W-1:0]    rdata,
	output pftex_pkg::mreq_t               mreq,
	output logic                           done
);
	import pftex_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROW,
		S_STAMP,
		S_SWEEP
	} state_t;

	state_t              state_q;
	logic                mode_q;
	hot_arr_t            hot_q;
	logic [SPOT_W-1:0]   spot_q;
	logic [STEP_W-1:0]   step_q;
	logic [IDX_W-1:0]    idx_q;
	logic [EXT_W-1:0]    acc_q;
	logic                zero_q;

	logic                is_ff;
	logic [EXT_W-1:0]    stamp_ctr;
	logic [EXT_W-1:0]    stamp_addr;
	logic [EXT_W-1:0]    rd_addr;
	logic [PIX_W-1:0]    data;
	logic [EXT_W-1:0]    term;
	logic [EXT_W-1:0]    sum;
	logic                last_step;
	logic                last_stamp;
	logic                last_idx;
	logic                col_end;

	function automatic logic [EXT_W-1:0] stamp_off(input logic ff, input logic [STEP_W-1:0] s);
		logic [EXT_W-1:0] r;
		case (s)
			3'd0:    r = '0;
			3'd1:    r = EXT_W'(1);
			3'd2:    r = EXT_W'(-1);
			3'd3:    r = EXT_W'(-GRID_W);
			3'd4:    r = ff ? EXT_W'(GRID_W) : EXT_W'(1 - GRID_W);
			default: r = EXT_W'(-1 - GRID_W);
		endcase
		return r;
	endfunction

	function automatic logic [EXT_W-1:0] fire_off(input logic [STEP_W-1:0] s);
		logic [EXT_W-1:0] r;
		case (s)
			3'd0:    r = EXT_W'(GRID_W - 1);
			3'd1:    r = EXT_W'(GRID_W + 1);
			3'd2:    r = EXT_W'(2 * GRID_W);
			3'd3:    r = EXT_W'(-2 * GRID_W);
			default: r = EXT_W'(-GRID_W);
		endcase
		return r;
	endfunction

	always_comb begin
		is_ff = (mode_q == MODE_FORCE);
		if (is_ff) begin
			stamp_ctr = ((EXT_W'(hot_q[0]) + EXT_W'(1)) << COL_W) + EXT_W'(hot_q[1]) + EXT_W'(1);
		end else begin
			stamp_ctr = EXT_W'(FIRE_BASE - HOT_BIAS) + EXT_W'(hot_q[spot_q]);
		end
		stamp_addr = stamp_ctr + stamp_off(is_ff, step_q);

		if (is_ff) begin
			case (step_q)
				3'd0:    rd_addr = {1'b0, idx_q};
				3'd1:    rd_addr = {1'b0, idx_q - IDX_W'(GRID_W)};
				default: rd_addr = {1'b0, idx_q - IDX_W'(1)};
			endcase
		end else begin
			rd_addr = {1'b0, idx_q} + fire_off(step_q);
		end

		data = zero_q ? '0 : rdata;
		if (!is_ff && (step_q inside {[3'd1:3'd3]})) begin
			term = EXT_W'({data, 1'b0});
		end else begin
			term = EXT_W'(data);
		end
		sum = acc_q + term;

		last_step  = is_ff ? (step_q == 3'd3) : (step_q == 3'd5);
		last_stamp = is_ff ? (step_q == 3'd4) : (step_q == 3'd5);
		col_end    = (idx_q[COL_W-1:0] == COL_W'(LAST_IN));
		last_idx   = is_ff ? (idx_q == '1) : (col_end && idx_q[IDX_W-1:COL_W] == COL_W'(LAST_IN));

		mreq = '0;
		case (state_q)
			S_ROW: begin
				mreq.we     = 1'b1;
				mreq.wfront = 1'b1;
				mreq.widx   = IDX_W'(BOTTOM_ROW) + IDX_W'(idx_q[COL_W-1:0]);
				mreq.wdata  = '0;
			end
			S_STAMP: begin
				mreq.we     = ~stamp_addr[IDX_W];
				mreq.wfront = 1'b1;
				mreq.widx   = stamp_addr[IDX_W-1:0];
				mreq.wdata  = PIX_HOT;
			end
			S_SWEEP: begin
				mreq.re     = ~last_step;
				mreq.ridx   = rd_addr[IDX_W-1:0];
				mreq.we     = last_step;
				mreq.wfront = 1'b0;
				mreq.widx   = idx_q;
				if (!is_ff) begin
					mreq.wdata = sum[EXT_W-1:3];
				end else if (sum < EXT_W'(2)) begin
					mreq.wdata = '0;
				end else begin
					mreq.wdata = PIX_W'((sum - EXT_W'(2)) >> 2);
				end
			end
			default: mreq = '0;
		endcase

		done = (state_q == S_SWEEP) && last_step && last_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_FIRE;
			hot_q   <= '0;
			spot_q  <= '0;
			step_q  <= '0;
			idx_q   <= '0;
			acc_q   <= '0;
			zero_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						hot_q   <= hot;
						spot_q  <= '0;
						step_q  <= '0;
						idx_q   <= '0;
						state_q <= (mode == MODE_FORCE) ? S_STAMP : S_ROW;
					end
				end
				S_ROW: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q[COL_W-1:0] == '1) begin
						state_q <= S_STAMP;
					end
				end
				S_STAMP: begin
					if (last_stamp) begin
						step_q <= '0;
						if (is_ff || spot_q == SPOT_W'(NUM_HOT - 1)) begin
							idx_q   <= is_ff ? '0 : IDX_W'(GRID_W + 1);
							state_q <= S_SWEEP;
						end else begin
							spot_q <= spot_q + SPOT_W'(1);
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_SWEEP: begin
					zero_q <= rd_addr[IDX_W] & ~is_ff;
					acc_q  <= (step_q == '0) ? '0 : sum;
					if (last_step) begin
						step_q <= '0;
						if (last_idx) begin
							state_q <= S_IDLE;
						end else if (!is_ff && col_end) begin
							idx_q <= idx_q + IDX_W'(3);
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/procedural_fire_forcefield_texture_core.sv @@
// top level of the fire / forcefield texture generator
//
// channels: cfg (cfg_valid/cfg_ready/cfg_data) sets effect_mode, 0 fire, 1 forcefield;
// in (in_valid/in_ready) carries kind, hot_0..hot_8 and read_address;
// out (out_valid/out_ready) carries pixel_value, one beat per read item only.
// two 32x32 byte textures share one 2048 x 8 ram; the front one is read and gets
// row clears and stamps, the back one gets sweep writes; they swap at frame end.
// after reset a clearing pass writes zero to all 2048 entries with in_ready low;
// cfg beats are taken at any time.
// a read item is a ram read, then a load of the output register when it is free.
// a fire frame has 32 row clears and 54 stamp steps, then five ram reads through
// the single read port and one write for each of 900 interior pixels.
// a forcefield frame has 5 stamp steps, then three reads and one write for each
// of 1024 pixels.
// the output register holds a result until it is taken; a frame item can be
// accepted while it waits, and a further read waits until the register frees.
module procedural_fire_forcefield_texture_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic [pftex_pkg::HOT_W-1:0]      hot_0,
	input  logic [pftex_pkg::HOT_W-1:0]      hot_1,
	input  logic [pftex_pkg::HOT_W-1:0]      hot_2,
	input  logic [pftex_pkg::HOT_W-1:0]      hot_3,
	input  logic [pftex_pkg::HOT_W-1:0]      hot_4,
	input  logic [pftex_pkg::HOT_W-1:0]      hot_5,
	input  logic [pftex_pkg::HOT_W-1:0]      hot_6,
	input  logic [pftex_pkg::HOT_W-1:0]      hot_7,
	input  logic [pftex_pkg::HOT_W-1:0]      hot_8,
	input  logic [pftex_pkg::IDX_W-1:0]      read_address,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pftex_pkg::PIX_W-1:0]      pixel_value
);
	import pftex_pkg::*;

	typedef enum logic [1:0] {
		T_CLR,
		T_IDLE,
		T_FRAME,
		T_READ
	} state_t;

	state_t              state_q;
	logic [CLR_W-1:0]    clr_q;
	logic                front_sel_q;
	logic                mode_q;
	logic                out_valid_q;
	logic [PIX_W-1:0]    pixel_q;

	logic                in_beat;
	logic                start;
	logic                out_free;
	logic                out_load;
	hot_arr_t            hot;
	mreq_t               mreq;
	logic                eng_done;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [PIX_W-1:0]    ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [PIX_W-1:0]    ram_rdata;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == T_IDLE);
	assign in_beat     = in_valid && in_ready;
	assign start       = in_beat && (kind == KIND_FRAME);
	assign out_free    = !out_valid_q || out_ready;
	assign out_load    = (state_q == T_READ) && out_free;
	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_q;
	assign hot = {hot_8, hot_7, hot_6, hot_5, hot_4, hot_3, hot_2, hot_1, hot_0};

	pftex_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode_q),
		.hot    (hot),
		.rdata  (ram_rdata),
		.mreq   (mreq),
		.done   (eng_done)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = {front_sel_q, read_address};
		case (state_q)
			T_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			T_IDLE: begin
				ram_re = in_beat && (kind == KIND_READ);
			end
			T_FRAME: begin
				ram_we    = mreq.we;
				ram_waddr = {mreq.wfront ? front_sel_q : ~front_sel_q, mreq.widx};
				ram_wdata = mreq.wdata;
				ram_re    = mreq.re;
				ram_raddr = {front_sel_q, mreq.ridx};
			end
			default: ram_re = 1'b0;
		endcase
	end

	pftex_ram #(
		.W (PIX_W),
		.D (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_CLR;
			clr_q       <= '0;
			front_sel_q <= 1'b0;
			mode_q      <= MODE_FIRE;
			out_valid_q <= 1'b0;
			pixel_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (out_load) begin
				pixel_q     <= ram_rdata;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_CLR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == '1) begin
						state_q <= T_IDLE;
					end
				end
				T_IDLE: begin
					if (in_beat) begin
						state_q <= (kind == KIND_READ) ? T_READ : T_FRAME;
					end
				end
				T_FRAME: begin
					if (eng_done) begin
						front_sel_q <= ~front_sel_q;
						state_q     <= T_IDLE;
					end
				end
				T_READ: begin
					if (out_free) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("ram read and write hit the same entry");

	a_done_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |-> (state_q == T_FRAME))
		else $error("frame done outside a frame");

	a_swap_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(front_sel_q) |-> $past(eng_done))
		else $error("buffer swap without frame end");

	a_frame_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("input taken right after frame start");

	a_clr_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_CLR) |-> (!in_ready && !ram_re))
		else $error("activity during clearing pass");

endmodule
